// ===== sv/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and defaults of the multi-axis step planner.
// ----------------------------------------------------------------------------
package msp_pkg;

	localparam int NUM_AXES_DEF  = 4;
	localparam int STEP_BITS_DEF = 24;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_BEGIN  = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;
	localparam logic [1:0] REQ_CANCEL = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_BAD_ID  = 2'd2;
	localparam logic [1:0] ST_DUP_ID  = 2'd3;

	localparam logic [1:0] CFG_ACCEL   = 2'd0;
	localparam logic [1:0] CFG_START   = 2'd1;
	localparam logic [1:0] CFG_FASTEST = 2'd2;
	localparam logic [1:0] CFG_MIN_TPS = 2'd3;

	localparam logic [15:0] ACCEL_RST   = 16'd1;
	localparam logic [15:0] START_RST   = 16'd16000;
	localparam logic [15:0] FASTEST_RST = 16'd1;
	localparam logic [7:0]  MIN_TPS_RST = 8'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RAMP_GO,
		S_RAMP_WAIT,
		S_SCAN,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic used;
		logic wr_add;
		logic wr_brake;
		logic wr_ival;
		logic tick;
	} cell_ctl_t;

endpackage

// ===== sv/msp_div.sv =====
// ----------------------------------------------------------------------------
// msp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msp_div #(
	parameter int W = msp_pkg::STEP_BITS_DEF + 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quotient,
	output logic         done
);
	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q, quo_q, div_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, done_q;
	logic [W:0]    trial, diff;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// ===== sv/msp_cell.sv =====
// ----------------------------------------------------------------------------
// msp_cell
// One axis slot: holds its move, advances it on a tick and folds its step,
// direction and speed into the chain running through all slots.
// ----------------------------------------------------------------------------
module msp_cell #(
	parameter int STEP_BITS = msp_pkg::STEP_BITS_DEF,
	parameter int DIV_W     = msp_pkg::STEP_BITS_DEF + 8
) (
	input  logic                  clk,
	input  msp_pkg::cell_ctl_t    ctl,
	input  logic [3:0]            add_axis,
	input  logic [STEP_BITS-1:0]  add_target,
	input  logic [15:0]           brake_in,
	input  logic [DIV_W-1:0]      ival_in,
	input  logic [15:0]           accel,
	input  logic [15:0]           start_mult,
	input  logic [15:0]           fast_mult,
	input  logic [3:0]            dup_id,
	input  logic [15:0]           mult_in,
	input  logic [3:0]            mask_in,
	input  logic [3:0]            dir_in,
	input  logic                  act_in,
	input  logic                  dup_in,
	output logic [15:0]           mult_out,
	output logic [3:0]            mask_out,
	output logic [3:0]            dir_out,
	output logic                  act_out,
	output logic                  dup_out,
	output logic [STEP_BITS-1:0]  mag
);
	localparam int CW = (DIV_W > 32) ? DIV_W : 32;
	localparam int SW = STEP_BITS + 17;

	logic [3:0]           axis_q;
	logic [STEP_BITS-1:0] target_q, done_q, done_nx;
	logic [31:0]          tick_q, tc, tc_sub;
	logic [DIV_W-1:0]     ival_q;
	logic [15:0]          brake_q, speed_q, up, dn, spd_nx;
	logic [16:0]          fa, sa;
	logic                 active, fire, brake_hit, step;

	assign mag     = target_q[STEP_BITS-1] ? (~target_q + 1'b1) : target_q;
	assign active  = ctl.used && (done_q < mag);
	assign tc      = tick_q + 32'd1;
	assign fire    = CW'(tc) >= CW'(ival_q);
	assign tc_sub  = tc - 32'(ival_q);
	assign done_nx = done_q + 1'b1;
	assign brake_hit = (SW'(done_nx) + SW'(brake_q)) >= SW'(mag);

	assign fa = 17'(fast_mult) + 17'(accel);
	assign sa = 17'(speed_q) + 17'(accel);
	assign up = (speed_q > fast_mult) ?
		((17'(speed_q) > fa) ? (speed_q - accel) : fast_mult) : speed_q;
	assign dn = (speed_q < start_mult) ?
		((sa > 17'(start_mult)) ? start_mult : sa[15:0]) : start_mult;
	assign spd_nx = fire ? (brake_hit ? dn : up) : speed_q;
	assign step   = active && fire;

	assign mult_out = (active && (spd_nx > mult_in)) ? spd_nx : mult_in;
	assign mask_out = mask_in | (step ? (4'b0001 << axis_q) : 4'b0000);
	assign dir_out  = dir_in | ((ctl.used && (target_q != '0) && !target_q[STEP_BITS-1]) ?
		(4'b0001 << axis_q) : 4'b0000);
	assign act_out  = act_in | active;
	assign dup_out  = dup_in | (ctl.used && (axis_q == dup_id));

	always_ff @(posedge clk) begin
		if (ctl.wr_add) begin
			axis_q   <= add_axis;
			target_q <= add_target;
			done_q   <= '0;
			tick_q   <= '0;
			ival_q   <= '0;
			brake_q  <= '0;
			speed_q  <= '0;
		end else if (ctl.wr_ival) begin
			ival_q  <= ival_in;
			done_q  <= '0;
			tick_q  <= '0;
			speed_q <= start_mult;
		end else if (ctl.wr_brake) begin
			brake_q <= brake_in;
		end else if (ctl.tick && ctl.used) begin
			tick_q <= step ? tc_sub : tc;
			if (step) begin
				done_q  <= done_nx;
				speed_q <= spd_nx;
			end
		end
	end
endmodule

// ===== sv/multi_axis_step_planner_top.sv =====
// ----------------------------------------------------------------------------
// multi_axis_step_planner_top
// Coordinated multi-axis step planner with trapezoidal speed ramp.
// ----------------------------------------------------------------------------
// Each transfer taken on start (while busy is low) gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it. Add move,
// tick and cancel results are registered and follow in the cycle after the
// transfer. Begin runs one shared bit-serial divider for the ramp length, steps
// through one scan state per queued axis for the braking points, then runs the
// divider once per queued axis for the step intervals and passes one closing
// state, and the result follows in the cycle after the closing state. The axis
// slots form a chain of cells updated in parallel on a tick.
module multi_axis_step_planner_top #(
	parameter int NUM_AXES  = msp_pkg::NUM_AXES_DEF,
	parameter int STEP_BITS = msp_pkg::STEP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [3:0]           motor_id,
	input  logic [STEP_BITS-1:0] steps,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [15:0]          wr_data,
	output logic                 done,
	output logic [1:0]           status,
	output logic [15:0]          period_multiplier,
	output logic [3:0]           step_mask,
	output logic [3:0]           direction_mask
);
	localparam int DIV_W = STEP_BITS + 8;
	localparam int UW    = $clog2(NUM_AXES + 1);
	localparam int IW    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	msp_pkg::state_t state_q, state_nx;

	logic [15:0] accel_q, start_q, fast_q;
	logic [7:0]  min_tps_q;
	logic [UW-1:0] used_q, idx_q;
	logic        halted_q;
	logic [15:0] ramp_q;
	logic [DIV_W-1:0] max_q;

	logic        done_q;
	logic [1:0]  status_q;
	logic [15:0] mult_q;
	logic [3:0]  mask_q;

	msp_pkg::cell_ctl_t ctl [NUM_AXES];
	logic [15:0] mult_c [NUM_AXES+1];
	logic [3:0]  mask_c [NUM_AXES+1];
	logic [3:0]  dir_c  [NUM_AXES+1];
	logic        act_c  [NUM_AXES+1];
	logic        dup_c  [NUM_AXES+1];
	logic [STEP_BITS-1:0] mag_c [NUM_AXES];

	logic accept, add_ok, ramp_ok, idx_last;
	logic div_go, div_done;
	logic [DIV_W-1:0] div_a, div_b, quo, need, half;
	logic [STEP_BITS-1:0] mag_sel;
	logic [15:0] brake_w;

	assign accept   = start && !busy;
	assign busy     = state_q != msp_pkg::S_IDLE;
	assign add_ok   = accept && (req_type == msp_pkg::REQ_ADD) &&
		(8'(motor_id) < 8'(NUM_AXES)) && !dup_c[NUM_AXES] && (used_q < UW'(NUM_AXES));
	assign ramp_ok  = (accel_q != 16'd0) && (start_q > fast_q);
	assign mag_sel  = mag_c[idx_q[IW-1:0]];
	assign idx_last = (idx_q + 1'b1) == used_q;
	assign need     = DIV_W'(mag_sel) * DIV_W'(min_tps_q);
	assign half     = need >> 1;
	assign brake_w  = (DIV_W'(ramp_q) < half) ? ramp_q : half[15:0];

	assign mult_c[0] = 16'd0;
	assign mask_c[0] = 4'd0;
	assign dir_c[0]  = 4'd0;
	assign act_c[0]  = 1'b0;
	assign dup_c[0]  = 1'b0;

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_cell
		always_comb begin
			ctl[i].used     = used_q > UW'(i);
			ctl[i].wr_add   = add_ok && (used_q == UW'(i));
			ctl[i].wr_brake = (state_q == msp_pkg::S_SCAN) && (idx_q == UW'(i));
			ctl[i].wr_ival  = (state_q == msp_pkg::S_DIV_WAIT) && div_done &&
				(idx_q == UW'(i));
			ctl[i].tick     = accept && (req_type == msp_pkg::REQ_TICK) && !halted_q;
		end

		msp_cell #(.STEP_BITS(STEP_BITS), .DIV_W(DIV_W)) u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.add_axis   (motor_id),
			.add_target (steps),
			.brake_in   (brake_w),
			.ival_in    ((mag_sel != '0) ? quo : '0),
			.accel      (accel_q),
			.start_mult (start_q),
			.fast_mult  (fast_q),
			.dup_id     (motor_id),
			.mult_in    (mult_c[i]),
			.mask_in    (mask_c[i]),
			.dir_in     (dir_c[i]),
			.act_in     (act_c[i]),
			.dup_in     (dup_c[i]),
			.mult_out   (mult_c[i+1]),
			.mask_out   (mask_c[i+1]),
			.dir_out    (dir_c[i+1]),
			.act_out    (act_c[i+1]),
			.dup_out    (dup_c[i+1]),
			.mag        (mag_c[i])
		);
	end

	assign div_a = (state_q == msp_pkg::S_RAMP_GO) ? DIV_W'(start_q - fast_q) : max_q;
	assign div_b = (state_q == msp_pkg::S_RAMP_GO) ? DIV_W'(accel_q) : DIV_W'(mag_sel);

	msp_div #(.W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (quo),
		.done     (div_done)
	);

	always_comb begin
		state_nx = state_q;
		div_go   = 1'b0;
		case (state_q)
			msp_pkg::S_IDLE: begin
				if (accept && (req_type == msp_pkg::REQ_BEGIN))
					state_nx = msp_pkg::S_RAMP_GO;
			end
			msp_pkg::S_RAMP_GO: begin
				div_go   = 1'b1;
				state_nx = msp_pkg::S_RAMP_WAIT;
			end
			msp_pkg::S_RAMP_WAIT: begin
				if (div_done)
					state_nx = (used_q == '0) ? msp_pkg::S_FINISH : msp_pkg::S_SCAN;
			end
			msp_pkg::S_SCAN: begin
				if (idx_last)
					state_nx = msp_pkg::S_DIV_GO;
			end
			msp_pkg::S_DIV_GO: begin
				div_go   = 1'b1;
				state_nx = msp_pkg::S_DIV_WAIT;
			end
			msp_pkg::S_DIV_WAIT: begin
				if (div_done)
					state_nx = idx_last ? msp_pkg::S_FINISH : msp_pkg::S_DIV_GO;
			end
			msp_pkg::S_FINISH: begin
				state_nx = msp_pkg::S_IDLE;
			end
			default: begin
				state_nx = msp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msp_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q   <= msp_pkg::ACCEL_RST;
			start_q   <= msp_pkg::START_RST;
			fast_q    <= msp_pkg::FASTEST_RST;
			min_tps_q <= msp_pkg::MIN_TPS_RST;
			used_q    <= '0;
			idx_q     <= '0;
			halted_q  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					msp_pkg::CFG_ACCEL:   accel_q   <= wr_data;
					msp_pkg::CFG_START:   start_q   <= wr_data;
					msp_pkg::CFG_FASTEST: fast_q    <= wr_data;
					msp_pkg::CFG_MIN_TPS: min_tps_q <= wr_data[7:0];
					default: ;
				endcase
			end
			done_q <= 1'b0;
			if (add_ok)
				used_q <= used_q + 1'b1;
			if (accept) begin
				done_q <= (req_type != msp_pkg::REQ_BEGIN);
				if (req_type == msp_pkg::REQ_CANCEL)
					halted_q <= 1'b1;
			end
			case (state_q)
				msp_pkg::S_RAMP_WAIT: idx_q <= '0;
				msp_pkg::S_SCAN:      idx_q <= idx_last ? '0 : idx_q + 1'b1;
				msp_pkg::S_DIV_WAIT: begin
					if (div_done)
						idx_q <= idx_q + 1'b1;
				end
				msp_pkg::S_FINISH:    done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// result payload and begin scratch
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= msp_pkg::ST_OK;
			mult_q   <= 16'd0;
			mask_q   <= 4'd0;
			max_q    <= '0;
			case (req_type)
				msp_pkg::REQ_ADD: begin
					if (8'(motor_id) >= 8'(NUM_AXES))
						status_q <= msp_pkg::ST_BAD_ID;
					else if (dup_c[NUM_AXES])
						status_q <= msp_pkg::ST_DUP_ID;
				end
				msp_pkg::REQ_TICK: begin
					if (halted_q || !act_c[NUM_AXES]) begin
						status_q <= msp_pkg::ST_DONE;
					end
					if (!halted_q) begin
						mult_q <= mult_c[NUM_AXES];
						mask_q <= mask_c[NUM_AXES];
					end
				end
				default: ;
			endcase
		end
		if ((state_q == msp_pkg::S_RAMP_WAIT) && div_done)
			ramp_q <= ramp_ok ? quo[15:0] : 16'd0;
		if (state_q == msp_pkg::S_SCAN && need > max_q)
			max_q <= need;
		if (state_q == msp_pkg::S_FINISH) begin
			status_q <= msp_pkg::ST_OK;
			mult_q   <= (used_q != '0) ? start_q : 16'd0;
			mask_q   <= 4'd0;
		end
	end

	assign done              = done_q;
	assign status            = status_q;
	assign period_multiplier = mult_q;
	assign step_mask         = mask_q;
	assign direction_mask    = dir_c[NUM_AXES];
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Step planner testbench
// Drives add-move, begin, tick and cancel transfers into the planner under
// several ramp settings, predicts every result from its own model of the
// axis slots and checks each result field by field in order of acceptance.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1000000;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] mult;
		logic [3:0]  smask;
		logic [3:0]  dmask;
	} plan_result_t;

	class planner_scoreboard;
		int unsigned       accel, start_m, fastest_m, min_tps;
		logic [3:0]        axis[4];
		logic [23:0]       target[4];
		longint unsigned   done_steps[4], interval[4], brake[4];
		int unsigned       tick_cnt[4], speed[4];
		int unsigned       used;
		bit                halted;
		plan_result_t      pending[$];
		int                errors;

		function new();
			accel = 32'(msp_pkg::ACCEL_RST);
			start_m = 32'(msp_pkg::START_RST);
			fastest_m = 32'(msp_pkg::FASTEST_RST);
			min_tps = 32'(msp_pkg::MIN_TPS_RST);
			used = 0;
			halted = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				msp_pkg::CFG_ACCEL:   accel = 32'(val);
				msp_pkg::CFG_START:   start_m = 32'(val);
				msp_pkg::CFG_FASTEST: fastest_m = 32'(val);
				msp_pkg::CFG_MIN_TPS: min_tps = 32'(val[7:0]);
				default: ;
			endcase
		endfunction

		function longint unsigned distance(logic [23:0] t);
			logic [23:0] n;
			n = -t;
			return t[23] ? 64'(n) : 64'(t);
		endfunction

		function int unsigned faster(int unsigned s);
			if (s > fastest_m)
				s = (s > fastest_m + accel) ? s - accel : fastest_m;
			return s;
		endfunction

		function int unsigned slower(int unsigned s);
			if (s < start_m) begin
				s += accel;
				if (s > start_m)
					s = start_m;
			end else begin
				s = start_m;
			end
			return s;
		endfunction

		function void note(logic [1:0] req, logic [3:0] id, logic [23:0] st);
			plan_result_t r;
			longint unsigned max_ticks, ramp, need, d;
			int unsigned tc;
			bit dup;
			r.status = msp_pkg::ST_OK;
			r.mult = '0;
			r.smask = '0;
			case (req)
				msp_pkg::REQ_ADD: begin
					dup = 0;
					for (int i = 0; i < used; i++)
						if (axis[i] == id)
							dup = 1;
					if (id >= 4'd4) begin
						r.status = msp_pkg::ST_BAD_ID;
					end else if (dup) begin
						r.status = msp_pkg::ST_DUP_ID;
					end else if (used < 4) begin
						axis[used] = id;
						target[used] = st;
						done_steps[used] = 0;
						tick_cnt[used] = 0;
						interval[used] = 0;
						brake[used] = 0;
						speed[used] = 0;
						used++;
					end
				end
				msp_pkg::REQ_BEGIN: begin
					max_ticks = 0;
					ramp = 0;
					if (accel != 0 && start_m > fastest_m)
						ramp = 64'((start_m - fastest_m) / accel);
					for (int i = 0; i < used; i++) begin
						need = distance(target[i]) * 64'(min_tps);
						if (need > max_ticks)
							max_ticks = need;
						brake[i] = (ramp < need / 2) ? ramp : need / 2;
					end
					for (int i = 0; i < used; i++) begin
						d = distance(target[i]);
						interval[i] = (d != 0) ? max_ticks / d : 64'd0;
						done_steps[i] = 0;
						tick_cnt[i] = 0;
						speed[i] = start_m;
					end
					r.mult = (used != 0) ? 16'(start_m) : 16'd0;
				end
				msp_pkg::REQ_TICK: begin
					r.status = msp_pkg::ST_DONE;
					if (!halted) begin
						for (int i = 0; i < used; i++) begin
							d = distance(target[i]);
							tc = tick_cnt[i] + 32'd1;
							tick_cnt[i] = tc;
							if (done_steps[i] >= d)
								continue;
							r.status = msp_pkg::ST_OK;
							if (64'(tc) >= interval[i]) begin
								done_steps[i]++;
								tick_cnt[i] = tc - 32'(interval[i]);
								r.smask[axis[i][1:0]] = 1'b1;
								if (done_steps[i] + brake[i] >= d)
									speed[i] = slower(speed[i]);
								else
									speed[i] = faster(speed[i]);
							end
							if (speed[i] > 32'(r.mult))
								r.mult = 16'(speed[i]);
						end
					end
				end
				default: halted = 1;
			endcase
			r.dmask = '0;
			for (int i = 0; i < used; i++)
				if (target[i] != '0 && !target[i][23])
					r.dmask[axis[i][1:0]] = 1'b1;
			pending.push_back(r);
		endfunction

		function void check(logic [1:0] s, logic [15:0] m, logic [3:0] sm, logic [3:0] dm);
			plan_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (s !== e.status) begin
				$error("status expected %0d got %0d", e.status, s);
				errors++;
			end
			if (m !== e.mult) begin
				$error("period_multiplier expected %0d got %0d", e.mult, m);
				errors++;
			end
			if (sm !== e.smask) begin
				$error("step_mask expected %h got %h", e.smask, sm);
				errors++;
			end
			if (dm !== e.dmask) begin
				$error("direction_mask expected %h got %h", e.dmask, dm);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, start, busy, wr_en, done;
	logic [1:0]  req_type, wr_index, status;
	logic [3:0]  motor_id, step_mask, direction_mask;
	logic [23:0] steps;
	logic [15:0] wr_data, period_multiplier;

	planner_scoreboard sb = new();
	bit  idling = 1;
	int  cycles = 0;

	multi_axis_step_planner_top uut (.*);

	initial clk = 0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check(status, period_multiplier, step_mask, direction_mask);

	// Leave start high; the next transfer or gap decides its level.
	task send(logic [1:0] req, logic [3:0] id, logic [23:0] st);
		start <= 1'b1;
		req_type <= req;
		motor_id <= id;
		steps <= st;
		do @(posedge clk); while (busy);
		sb.note(req, id, st);
		if (idling && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task random_item(bit allow_cancel);
		int unsigned r;
		logic [23:0] st;
		r = $urandom_range(0, 99);
		st = 24'($urandom());
		if (st == 24'h800000)
			st = 24'h7fffff;
		if (r < 12)
			send(msp_pkg::REQ_ADD, 4'($urandom_range(0, 15)), st);
		else if (r < 17)
			send(msp_pkg::REQ_BEGIN, 4'($urandom_range(0, 15)), st);
		else if (allow_cancel && r < 20)
			send(msp_pkg::REQ_CANCEL, 4'($urandom_range(0, 15)), st);
		else
			send(msp_pkg::REQ_TICK, 4'($urandom_range(0, 15)), st);
	endtask

	logic [15:0] cfg_tab[7][4] = '{
		'{16'd1, 16'd16000, 16'd1, 16'd1},
		'{16'd65535, 16'd65535, 16'd1, 16'd255},
		'{16'd0, 16'd100, 16'd50, 16'd3},
		'{16'd7, 16'd10, 16'd20, 16'd1},
		'{16'd300, 16'd5000, 16'd200, 16'd2},
		'{16'd1, 16'd1, 16'd65535, 16'd1},
		'{16'd3, 16'd40, 16'd2, 16'd1}
	};

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= msp_pkg::REQ_TICK;
		motor_id <= '0;
		steps <= '0;
		wr_en <= 1'b0;
		wr_index <= msp_pkg::CFG_ACCEL;
		wr_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty planner, bad and duplicate axes, tick before begin.
		send(msp_pkg::REQ_BEGIN, 4'd0, 24'd0);
		send(msp_pkg::REQ_TICK, 4'd0, 24'd0);
		send(msp_pkg::REQ_ADD, 4'd4, 24'h7fffff);
		send(msp_pkg::REQ_ADD, 4'd15, 24'h800001);
		send(msp_pkg::REQ_ADD, 4'd2, 24'd7);
		send(msp_pkg::REQ_ADD, 4'd2, 24'd9);
		send(msp_pkg::REQ_TICK, 4'd0, 24'd0);
		send(msp_pkg::REQ_ADD, 4'd0, -24'sd4);
		send(msp_pkg::REQ_ADD, 4'd1, 24'd0);
		send(msp_pkg::REQ_ADD, 4'd3, 24'd40);
		send(msp_pkg::REQ_ADD, 4'd3, 24'd1);
		send(msp_pkg::REQ_BEGIN, 4'd0, 24'd0);
		repeat (12) send(msp_pkg::REQ_TICK, 4'd0, 24'd0);

		for (int p = 0; p < 7; p++) begin
			drain();
			for (int k = 0; k < 4; k++)
				write_reg(k[1:0], cfg_tab[p][k]);
			send(msp_pkg::REQ_BEGIN, 4'd0, 24'd0);
			for (int n = 0; n < 215; n++) begin
				if (p == 6)
					idling = 0;
				if (p == 2 && n == 100)
					drain();
				random_item(p == 6 && n >= 180);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/msp_pkg.sv
sv/msp_div.sv
sv/msp_cell.sv
sv/multi_axis_step_planner_top.sv
tb/testbench.sv
